// ===== rtl/vml_pkg.sv =====
// Shared types and constants of the look-at view matrix block.
`default_nettype none
package vml_pkg;

   // Width of a normalized magnitude: values lie in [0, 2^30 - 1].
   localparam int NORM_BITS = 30;

   localparam logic signed [31:0] ONE_Q30  = 32'sh4000_0000;
   localparam logic signed [65:0] HALF_Q30 = 66'sh0_2000_0000;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] side_0;
      logic signed [31:0] side_1;
      logic signed [31:0] side_2;
      logic signed [31:0] upright_0;
      logic signed [31:0] upright_1;
      logic signed [31:0] upright_2;
      logic signed [31:0] back_0;
      logic signed [31:0] back_1;
      logic signed [31:0] back_2;
      logic signed [31:0] shift_side;
      logic signed [31:0] shift_upright;
      logic signed [31:0] shift_back;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/vml_chan_if.sv =====
// Valid/ready channel carrying one payload item per transfer.
`default_nettype none
interface vml_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/vml_norm.sv =====
// Pipelined 3-vector normalizer: scale, sum of squares, root and divide, one bit per stage.
`default_nettype none
module vml_norm #(
   parameter int W  = 33,
   parameter int SW = 192
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ce,
   input  logic                 in_valid,
   input  logic [2:0][W-1:0]    in_vec,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic [2:0][31:0]     out_vec,
   output logic [SW-1:0]        out_side
);
   localparam int NB = vml_pkg::NORM_BITS;
   localparam int PW = $clog2(W);
   localparam int RB = NB + 1;          // root and quotient bits
   localparam int QW = 2 * NB + 2;      // sum of three squares
   localparam int DW = 2 * NB + 1;      // dividend
   localparam int XW = W + NB;
   localparam int TW = SW + 4;          // side, three signs, zero flag

   logic [5:1] vp_ff;

   logic [2:0][W-1:0]  a1_ff, a2_ff, a3_ff;
   logic [SW+2:0]      t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   logic [W-1:0]       m2_ff, m2_in;
   logic [PW-1:0]      p3_ff, p3_in;
   logic               z3_ff, z4_ff, z5_ff;
   logic [2:0][NB-1:0] a4_ff, a4_in, a5_ff;
   logic [2:0][2*NB-1:0] sq5_ff;
   logic [XW-1:0]      sh4 [0:2];

   logic              qv_ff [0:RB];
   logic [QW-1:0]     qr_ff [0:RB];
   logic [RB-1:0]     qn_ff [0:RB];
   logic [3*NB-1:0]   qa_ff [0:RB];
   logic [TW-1:0]     qt_ff [0:RB];

   logic              dv_ff [0:RB];
   logic [DW-1:0]     dr_ff [0:RB][0:2];
   logic [RB-1:0]     dq_ff [0:RB][0:2];
   logic [RB-1:0]     dn_ff [0:RB];
   logic [TW-1:0]     dt_ff [0:RB];

   logic              ov_ff;
   logic [2:0][31:0]  o_ff, o_in;
   logic [SW-1:0]     os_ff;

   // front stages: magnitude, max, leading one, scale, squares
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= '0;
      end else if (ce) begin
         vp_ff <= {vp_ff[4:1], in_valid};
      end
   end

   always_comb begin
      m2_in = a1_ff[0];
      if (a1_ff[1] > m2_in) m2_in = a1_ff[1];
      if (a1_ff[2] > m2_in) m2_in = a1_ff[2];
   end

   always_comb begin
      p3_in = '0;
      for (int b = 0; b < W; b++) begin
         if (m2_ff[b]) p3_in = PW'(b);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (p3_ff >= PW'(NB - 1)) begin
            sh4[i] = XW'(a3_ff[i]) >> (p3_ff - PW'(NB - 1));
         end else begin
            sh4[i] = XW'(a3_ff[i]) << (PW'(NB - 1) - p3_ff);
         end
         a4_in[i] = sh4[i][NB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            a1_ff[i]  <= in_vec[i][W-1] ? W'(-in_vec[i]) : in_vec[i];
            sq5_ff[i] <= (2*NB)'(a4_ff[i]) * (2*NB)'(a4_ff[i]);
         end
         t1_ff <= {in_side, in_vec[2][W-1], in_vec[1][W-1], in_vec[0][W-1]};
         a2_ff <= a1_ff;
         m2_ff <= m2_in;
         t2_ff <= t1_ff;
         a3_ff <= a2_ff;
         p3_ff <= p3_in;
         z3_ff <= (m2_ff == '0);
         t3_ff <= t2_ff;
         a4_ff <= a4_in;
         z4_ff <= z3_ff;
         t4_ff <= t3_ff;
         a5_ff <= a4_ff;
         z5_ff <= z4_ff;
         t5_ff <= t4_ff;
      end
   end

   // square root entry
   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff[0] <= 1'b0;
      end else if (ce) begin
         qv_ff[0] <= vp_ff[5];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         qr_ff[0] <= QW'(sq5_ff[0]) + QW'(sq5_ff[1]) + QW'(sq5_ff[2]);
         qn_ff[0] <= '0;
         qa_ff[0] <= a5_ff;
         qt_ff[0] <= {t5_ff, z5_ff};
      end
   end

   // one root bit per stage, most significant first
   for (genvar j = 0; j < RB; j++) begin : g_sqrt
      localparam int K = RB - 1 - j;
      logic [QW:0] trial;
      logic        take;

      assign trial = ((QW+1)'(qn_ff[j]) << (K + 1)) + ((QW+1)'(1) << (2 * K));
      assign take  = {1'b0, qr_ff[j]} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            qv_ff[j+1] <= 1'b0;
         end else if (ce) begin
            qv_ff[j+1] <= qv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            qr_ff[j+1] <= take ? QW'({1'b0, qr_ff[j]} - trial) : qr_ff[j];
            qn_ff[j+1] <= take ? (qn_ff[j] | (RB'(1) << K)) : qn_ff[j];
            qa_ff[j+1] <= qa_ff[j];
            qt_ff[j+1] <= qt_ff[j];
         end
      end
   end

   // divider entry: dividend is a * 2^30 + n / 2
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (ce) begin
         dv_ff[0] <= qv_ff[RB];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            dr_ff[0][i] <= {1'b0, qa_ff[RB][NB*i +: NB], NB'(0)} + DW'(qn_ff[RB] >> 1);
            dq_ff[0][i] <= '0;
         end
         dn_ff[0] <= qn_ff[RB];
         dt_ff[0] <= qt_ff[RB];
      end
   end

   // one quotient bit per stage for all three components
   for (genvar j = 0; j < RB; j++) begin : g_div
      localparam int K = RB - 1 - j;
      logic [DW:0] dsh;
      logic [2:0]  dtk;

      assign dsh = (DW+1)'(dn_ff[j]) << K;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            dtk[i] = {1'b0, dr_ff[j][i]} >= dsh;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (ce) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            for (int i = 0; i < 3; i++) begin
               dr_ff[j+1][i] <= dtk[i] ? DW'({1'b0, dr_ff[j][i]} - dsh) : dr_ff[j][i];
               dq_ff[j+1][i] <= dtk[i] ? (dq_ff[j][i] | (RB'(1) << K)) : dq_ff[j][i];
            end
            dn_ff[j+1] <= dn_ff[j];
            dt_ff[j+1] <= dt_ff[j];
         end
      end
   end

   // apply sign, force zero vectors to zero
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dt_ff[RB][0]) begin
            o_in[i] = '0;
         end else if (dt_ff[RB][i+1]) begin
            o_in[i] = 32'(0) - 32'(dq_ff[RB][i]);
         end else begin
            o_in[i] = 32'(dq_ff[RB][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (ce) begin
         ov_ff <= dv_ff[RB];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         o_ff  <= o_in;
         os_ff <= dt_ff[RB][TW-1:4];
      end
   end

   assign out_valid = ov_ff;
   assign out_vec   = o_ff;
   assign out_side  = os_ff;

   a_scaled_max: assert property (@(posedge clock) disable iff (reset)
      vp_ff[5] && !z5_ff |-> (a5_ff[0][NB-1] || a5_ff[1][NB-1] || a5_ff[2][NB-1]))
      else $error("scaled maximum not in top octave");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      qv_ff[RB] && !qt_ff[RB][0] |-> (qn_ff[RB][RB-1:RB-2] != 2'b00))
      else $error("root below half scale for a nonzero vector");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> ($signed(o_ff[0]) <= vml_pkg::ONE_Q30 && $signed(o_ff[0]) >= -vml_pkg::ONE_Q30
              && $signed(o_ff[1]) <= vml_pkg::ONE_Q30 && $signed(o_ff[1]) >= -vml_pkg::ONE_Q30
              && $signed(o_ff[2]) <= vml_pkg::ONE_Q30 && $signed(o_ff[2]) >= -vml_pkg::ONE_Q30))
      else $error("normalized component above one");

endmodule
`default_nettype wire

// ===== rtl/view_matrix_from_eye_target_top.sv =====
// Top level: look-at view matrix from eye, target and up hint.
//
//  channel | dir | payload                         | transfer when
//  req     | in  | eye, target, up (Q16.16)        | req.valid && req.ready
//  rsp     | out | side/upright/back (Q1.30), shifts| rsp.valid && rsp.ready
//
// One item enters per cycle while rsp does not stall; an item passes three
// normalizers of 70 stages each, set by the bit-per-stage root and divide, plus 8 stages
// of difference, cross product, translation and output register.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A stall on rsp freezes the whole pipeline in place; req.ready drops only
// while the output register holds an item that is not taken.
`default_nettype none
module view_matrix_from_eye_target_top (
   input  logic        clock,
   input  logic        reset,
   vml_chan_if.sink    req,
   vml_chan_if.source  rsp
);
   logic ce;

   logic              va_ff;
   logic [2:0][32:0]  d_ff;
   logic [2:0][31:0]  ea_ff, ua_ff;

   logic              v1;
   logic [2:0][31:0]  z1, e1, u1;
   logic [191:0]      s1;

   logic              vb_ff, vc_ff;
   logic [5:0][63:0]  pb_ff;
   logic [2:0][31:0]  eb_ff, zb_ff, ec_ff, zc_ff;
   logic [2:0][64:0]  xr_ff;

   logic              v2;
   logic [2:0][31:0]  x2, e2, z2;
   logic [191:0]      s2;

   logic              vd_ff, ve_ff;
   logic [5:0][63:0]  pd_ff;
   logic [2:0][31:0]  ed_ff, zd_ff, xd_ff, ee_ff, ze_ff, xe_ff;
   logic [2:0][64:0]  yr_ff;

   logic              v3;
   logic [2:0][31:0]  y3, e3, z3, x3;
   logic [287:0]      s3;

   logic              vf_ff, vg_ff;
   logic [8:0][63:0]  pf_ff;
   logic [2:0][31:0]  xf_ff, yf_ff, zf_ff, xg_ff, yg_ff, zg_ff;
   logic [2:0][65:0]  tg_ff;
   logic [2:0][31:0]  sat_in;

   logic              rsp_valid_ff;
   vml_pkg::rsp_type  rsp_data_ff;

   function automatic logic signed [63:0] smul(input logic [31:0] a, input logic [31:0] b);
      smul = $signed(a) * $signed(b);
   endfunction

   function automatic logic [64:0] sdiff(input logic [63:0] a, input logic [63:0] b);
      sdiff = {a[63], a} - {b[63], b};
   endfunction

   function automatic logic [65:0] sx66(input logic [63:0] a);
      sx66 = {{2{a[63]}}, a};
   endfunction

   assign ce        = !rsp_valid_ff || rsp.ready;
   assign req.ready = ce;

   // stage A: back axis before normalization, exact 33-bit difference
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (ce) begin
         va_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         d_ff[0] <= {req.data.eye_x[31], req.data.eye_x} - {req.data.target_x[31], req.data.target_x};
         d_ff[1] <= {req.data.eye_y[31], req.data.eye_y} - {req.data.target_y[31], req.data.target_y};
         d_ff[2] <= {req.data.eye_z[31], req.data.eye_z} - {req.data.target_z[31], req.data.target_z};
         ea_ff   <= {req.data.eye_z, req.data.eye_y, req.data.eye_x};
         ua_ff   <= {req.data.up_z, req.data.up_y, req.data.up_x};
      end
   end

   vml_norm #(.W(33), .SW(192)) u_norm_back (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (va_ff),
      .in_vec   (d_ff),
      .in_side  ({ea_ff, ua_ff}),
      .out_valid(v1),
      .out_vec  (z1),
      .out_side (s1)
   );

   assign e1 = s1[191:96];
   assign u1 = s1[95:0];

   // stages B, C: side axis = up x back
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (ce) begin
         vb_ff <= v1;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pb_ff[0] <= smul(u1[1], z1[2]);
         pb_ff[1] <= smul(u1[2], z1[1]);
         pb_ff[2] <= smul(u1[2], z1[0]);
         pb_ff[3] <= smul(u1[0], z1[2]);
         pb_ff[4] <= smul(u1[0], z1[1]);
         pb_ff[5] <= smul(u1[1], z1[0]);
         eb_ff    <= e1;
         zb_ff    <= z1;
         xr_ff[0] <= sdiff(pb_ff[0], pb_ff[1]);
         xr_ff[1] <= sdiff(pb_ff[2], pb_ff[3]);
         xr_ff[2] <= sdiff(pb_ff[4], pb_ff[5]);
         ec_ff    <= eb_ff;
         zc_ff    <= zb_ff;
      end
   end

   vml_norm #(.W(65), .SW(192)) u_norm_side (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (vc_ff),
      .in_vec   (xr_ff),
      .in_side  ({ec_ff, zc_ff}),
      .out_valid(v2),
      .out_vec  (x2),
      .out_side (s2)
   );

   assign e2 = s2[191:96];
   assign z2 = s2[95:0];

   // stages D, E: upright axis = back x side
   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else if (ce) begin
         vd_ff <= v2;
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         pd_ff[0] <= smul(z2[1], x2[2]);
         pd_ff[1] <= smul(z2[2], x2[1]);
         pd_ff[2] <= smul(z2[2], x2[0]);
         pd_ff[3] <= smul(z2[0], x2[2]);
         pd_ff[4] <= smul(z2[0], x2[1]);
         pd_ff[5] <= smul(z2[1], x2[0]);
         ed_ff    <= e2;
         zd_ff    <= z2;
         xd_ff    <= x2;
         yr_ff[0] <= sdiff(pd_ff[0], pd_ff[1]);
         yr_ff[1] <= sdiff(pd_ff[2], pd_ff[3]);
         yr_ff[2] <= sdiff(pd_ff[4], pd_ff[5]);
         ee_ff    <= ed_ff;
         ze_ff    <= zd_ff;
         xe_ff    <= xd_ff;
      end
   end

   vml_norm #(.W(65), .SW(288)) u_norm_upright (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (ve_ff),
      .in_vec   (yr_ff),
      .in_side  ({ee_ff, ze_ff, xe_ff}),
      .out_valid(v3),
      .out_vec  (y3),
      .out_side (s3)
   );

   assign e3 = s3[287:192];
   assign z3 = s3[191:96];
   assign x3 = s3[95:0];

   // stages F, G: translation, -(row . eye) with half-up rounding offset
   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (ce) begin
         vf_ff <= v3;
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            pf_ff[i]     <= smul(x3[i], e3[i]);
            pf_ff[3 + i] <= smul(y3[i], e3[i]);
            pf_ff[6 + i] <= smul(z3[i], e3[i]);
         end
         xf_ff <= x3;
         yf_ff <= y3;
         zf_ff <= z3;
         for (int r = 0; r < 3; r++) begin
            tg_ff[r] <= vml_pkg::HALF_Q30
                      - (sx66(pf_ff[3*r]) + sx66(pf_ff[3*r + 1]) + sx66(pf_ff[3*r + 2]));
         end
         xg_ff <= xf_ff;
         yg_ff <= yf_ff;
         zg_ff <= zf_ff;
      end
   end

   // floor shift by 30, then clamp to the 32-bit range
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (tg_ff[r][65:61] == 5'b00000 || tg_ff[r][65:61] == 5'b11111) begin
            sat_in[r] = tg_ff[r][61:30];
         end else if (tg_ff[r][65]) begin
            sat_in[r] = 32'h8000_0000;
         end else begin
            sat_in[r] = 32'h7fff_ffff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= vg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_data_ff.side_0        <= xg_ff[0];
         rsp_data_ff.side_1        <= xg_ff[1];
         rsp_data_ff.side_2        <= xg_ff[2];
         rsp_data_ff.upright_0     <= yg_ff[0];
         rsp_data_ff.upright_1     <= yg_ff[1];
         rsp_data_ff.upright_2     <= yg_ff[2];
         rsp_data_ff.back_0        <= zg_ff[0];
         rsp_data_ff.back_1        <= zg_ff[1];
         rsp_data_ff.back_2        <= zg_ff[2];
         rsp_data_ff.shift_side    <= sat_in[0];
         rsp_data_ff.shift_upright <= sat_in[1];
         rsp_data_ff.shift_back    <= sat_in[2];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

endmodule
`default_nettype wire
